>>> hw/rtl/tew_pkg.sv
package tew_pkg;

  localparam logic [7:0] CH_NL   = 8'd10;
  localparam logic [7:0] CH_AMP  = 8'd38;
  localparam logic [7:0] CH_APOS = 8'd39;

  typedef struct packed {
    logic [7:0] text_char;
    logic       macro_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       truncated;
  } out_item_t;

  typedef enum logic [1:0] {
    CLS_SPECIAL = 2'd0,
    CLS_APOS    = 2'd1,
    CLS_DIGIT   = 2'd2,
    CLS_LETTER  = 2'd3
  } char_cls_t;

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_SEND    = 3'b010,
    ST_CLOSE   = 3'b100
  } state_t;

  function automatic char_cls_t char_class(input logic [7:0] ch);
    char_cls_t cls;
    if ((ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122)) begin
      cls = CLS_LETTER;
    end else if (ch >= 8'd48 && ch <= 8'd57) begin
      cls = CLS_DIGIT;
    end else if (ch == CH_APOS || ch == CH_AMP) begin
      cls = CLS_APOS;
    end else begin
      cls = CLS_SPECIAL;
    end
    return cls;
  endfunction

endpackage

>>> hw/rtl/text_word_extractor.sv
// text word extractor: one character item in on src, word characters out on dst.
// src carries text_char and macro_line; an item is taken when src_valid is high
// and src_stall is low. dst carries out_char, run_last and truncated under the
// same valid/stall rule; run_last marks the newline that closes each sent word.
// while a word is collected src is not stalled and nothing new is emitted;
// characters go into the word buffer memory, one write per cycle.
// the special character that ends a qualifying word starts emission: the buffer
// is read back one entry per cycle while dst does not stall, through its
// registered read port and then the output register, so a word of n kept
// characters gives n+1 items; src stalls in send and close states. the output
// register lets the next character in while the last item still waits on dst.
// words that fail the letter rules are dropped without stalling src.
// a stall on dst freezes the output register and the buffer read position.
// reset clears all word state and the output valid flag; the buffer contents are
// never read before they are written, so no clearing pass is done.
module text_word_extractor #(
  parameter int MAX_WORD = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  tew_pkg::in_item_t   src_item,
  output logic                dst_valid,
  input  logic                dst_stall,
  output tew_pkg::out_item_t  dst_item
);

  import tew_pkg::*;

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = $clog2(MAX_WORD);

  state_t         state;
  logic [LW-1:0]  word_length;
  logic [LW-1:0]  keep_len;
  logic [1:0]     letter_count;
  logic [1:0]     leading_letters;
  logic           in_word;
  logic           overflowed;
  logic           word_is_macro;
  logic [AW-1:0]  rd_idx;

  char_cls_t      cls;
  logic           src_accept;
  logic           is_letter;
  logic           word_start;
  logic           out_free;
  logic           qualify;
  logic           room;
  logic           last_char;
  logic [LW-1:0]  emit_len;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  assign src_stall  = (state != ST_COLLECT);
  assign src_accept = src_valid && !src_stall;
  assign cls        = char_class(src_item.text_char);
  assign is_letter  = (cls == CLS_LETTER);
  assign word_start = (cls == CLS_LETTER) || (cls == CLS_DIGIT);
  assign out_free   = !dst_valid || !dst_stall;
  assign room       = (word_length < LW'(MAX_WORD));
  assign emit_len   = overflowed ? word_length : keep_len;
  assign last_char  = ((LW'(rd_idx) + LW'(1)) == emit_len);

  always_comb begin
    if (word_is_macro) begin
      qualify = (letter_count > 2'd2) && (leading_letters == 2'd2);
    end else begin
      qualify = (letter_count > 2'd1);
    end
  end

  // buffer port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == ST_COLLECT && src_accept) begin
      if (!in_word) begin
        wr_en = word_start;
      end else if (cls != CLS_SPECIAL) begin
        wr_en   = room;
        wr_addr = word_length[AW-1:0];
      end else begin
        rd_en = qualify;
      end
    end else if (state == ST_SEND && out_free && !last_char) begin
      rd_en   = 1'b1;
      rd_addr = rd_idx + AW'(1);
    end
  end

  tew_mem #(
    .DEPTH (MAX_WORD)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (src_item.text_char),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_COLLECT;
      word_length     <= '0;
      keep_len        <= '0;
      letter_count    <= '0;
      leading_letters <= '0;
      in_word         <= 1'b0;
      overflowed      <= 1'b0;
      word_is_macro   <= 1'b0;
      rd_idx          <= '0;
      dst_valid       <= 1'b0;
    end else begin
      if (out_free) begin
        dst_valid <= (state == ST_SEND) || (state == ST_CLOSE);
      end
      case (state)
        ST_COLLECT: begin
          if (src_accept) begin
            if (!in_word) begin
              if (word_start) begin
                word_length     <= LW'(1);
                keep_len        <= LW'(1);
                letter_count    <= is_letter ? 2'd1 : 2'd0;
                leading_letters <= is_letter ? 2'd1 : 2'd0;
                overflowed      <= 1'b0;
                word_is_macro   <= src_item.macro_line;
                in_word         <= 1'b1;
              end
            end else if (cls != CLS_SPECIAL) begin
              if (word_length == LW'(1) && leading_letters == 2'd1 && is_letter) begin
                leading_letters <= 2'd2;
              end
              if (is_letter && letter_count != 2'd3) begin
                letter_count <= letter_count + 2'd1;
              end
              if (room) begin
                word_length <= word_length + LW'(1);
                // trailing apostrophes and ampersands are left out of the kept length
                if (cls != CLS_APOS) begin
                  keep_len <= word_length + LW'(1);
                end
              end else begin
                overflowed <= 1'b1;
              end
            end else begin
              in_word <= 1'b0;
              if (qualify) begin
                rd_idx <= '0;
                state  <= ST_SEND;
              end
            end
          end
        end
        ST_SEND: begin
          if (out_free) begin
            dst_item  <= '{out_char: rd_data, run_last: 1'b0, truncated: overflowed};
            if (last_char) begin
              state <= ST_CLOSE;
            end else begin
              rd_idx <= rd_idx + AW'(1);
            end
          end
        end
        ST_CLOSE: begin
          if (out_free) begin
            dst_item  <= '{out_char: CH_NL, run_last: 1'b1, truncated: overflowed};
            state     <= ST_COLLECT;
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    word_length <= LW'(MAX_WORD) && keep_len <= word_length)
    else $error("word length beyond buffer");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEND |-> LW'(rd_idx) < emit_len)
    else $error("buffer read past word end");

  a_close_nl: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.run_last |-> dst_item.out_char == CH_NL)
    else $error("closing item is not a newline");

  a_close_after_send: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLOSE |-> $past(state) == ST_SEND || $past(state) == ST_CLOSE)
    else $error("close entered without sending characters");

endmodule

>>> hw/rtl/tew_mem.sv
module tew_mem #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
